// ===== rtl/ib32_pkg.sv =====
// Shared types, constants and symbol functions for the interleaved base32 encoder.
`default_nettype none
package ib32_pkg;

  localparam int GROUP_LEN    = 5;
  localparam int HOLD_DEPTH   = 4;
  localparam int GROUP_BITS   = 8 * GROUP_LEN;
  localparam int SLICE_BITS   = 10;
  localparam int SYMS_PER_GRP = 8;
  localparam int PAD_W        = 3;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [6:0] LETTER_BASE  = 7'd97;
  localparam logic [6:0] DIGIT_BASE   = 7'd22;
  localparam logic [6:0] ZERO_CHAR    = 7'd48;
  localparam logic [4:0] LETTER_COUNT = 5'd26;
  localparam logic [7:0] PAD_MARK     = 8'h80;

  typedef struct packed {
    logic [GROUP_BITS-1:0] bits;
    logic                  last;
    logic [PAD_W-1:0]      pad;
  } group_t;

  function automatic logic [4:0] even_sym(input logic [SLICE_BITS-1:0] s);
    return {s[9], s[7], s[5], s[3], s[1]};
  endfunction

  function automatic logic [4:0] odd_sym(input logic [SLICE_BITS-1:0] s);
    return {s[8], s[6], s[4], s[2], s[0]};
  endfunction

  function automatic logic [6:0] sym_char(input logic [4:0] sym);
    logic [6:0] ext;
    ext = {2'b00, sym};
    if (sym < LETTER_COUNT) begin
      return ext + LETTER_BASE;
    end else begin
      return ext + DIGIT_BASE;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ib32_front.sv =====
// Front end: gathers input bytes into five-byte groups and pads the final group.
`default_nettype none
module ib32_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [7:0]      in_tdata,   // [7:0] data_byte
  input  wire logic            in_tlast,   // end_of_stream
  output logic                 push,
  output ib32_pkg::group_t     push_data,
  input  wire logic            q_full
);
  import ib32_pkg::*;

  logic [7:0]       grp_r [HOLD_DEPTH];
  logic [2:0]       held_r;
  logic [2:0]       held_nxt;
  logic             accept;
  logic             complete;
  logic [7:0]       gbyte [GROUP_LEN];
  logic [GROUP_BITS-1:0] bits;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign complete  = in_tlast || (held_r == 3'(HOLD_DEPTH));
  assign push      = accept && complete;

  always_comb begin
    for (int i = 0; i < GROUP_LEN; i++) begin
      if (3'(i) < held_r) begin
        gbyte[i] = grp_r[i % HOLD_DEPTH];
      end else if (3'(i) == held_r) begin
        gbyte[i] = in_tdata;
      end else if (3'(i) == held_r + 3'd1) begin
        gbyte[i] = PAD_MARK;
      end else begin
        gbyte[i] = 8'h00;
      end
    end
    for (int i = 0; i < GROUP_LEN; i++) begin
      bits[GROUP_BITS-1-8*i -: 8] = gbyte[i];
    end
  end

  assign push_data.bits = bits;
  assign push_data.last = in_tlast;
  assign push_data.pad  = 3'(GROUP_LEN - 1) - held_r;

  always_comb begin
    held_nxt = held_r;
    if (accept) begin
      if (complete) begin
        held_nxt = 3'd0;
      end else begin
        held_nxt = held_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 3'd0;
    end else begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      grp_r[held_r[1:0]] <= in_tdata;
    end
  end

`ifndef NO_ASSERTIONS
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 3'(HOLD_DEPTH))
    else $error("byte count beyond group depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/ib32_queue.sv =====
// Small group queue between the byte gatherer and the character serializer.
`default_nettype none
module ib32_queue #(
  parameter int DEPTH = ib32_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire ib32_pkg::group_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output ib32_pkg::group_t      q_data
);
  import ib32_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  group_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("group pushed into a full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/ib32_back.sv =====
// Back end: turns each queued group into eight characters and an optional pad digit.
`default_nettype none
module ib32_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire ib32_pkg::group_t q_data,
  output logic                  pop,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [6:0] text_char, [7] zero
  output logic                  out_tlast   // final_char
);
  import ib32_pkg::*;

  localparam logic [3:0] LAST_SYM  = 4'(SYMS_PER_GRP - 1);
  localparam logic [3:0] DIGIT_STP = 4'(SYMS_PER_GRP);

  logic                  busy_r, busy_nxt;
  logic [3:0]            step_r, step_nxt;
  logic [GROUP_BITS-1:0] cur_r, cur_nxt;
  logic                  last_r, last_nxt;
  logic [PAD_W-1:0]      pad_r, pad_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [7:0]            out_tdata_r, out_tdata_nxt;
  logic                  out_tlast_r, out_tlast_nxt;
  logic                  adv;
  logic [SLICE_BITS-1:0] slice;

  assign slice = cur_r[GROUP_BITS-1 -: SLICE_BITS];
  assign adv   = !out_tvalid_r || out_tready;

  always_comb begin
    busy_nxt       = busy_r;
    step_nxt       = step_r;
    cur_nxt        = cur_r;
    last_nxt       = last_r;
    pad_nxt        = pad_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    pop            = 1'b0;
    if (!busy_r) begin
      if (q_valid) begin
        pop      = 1'b1;
        busy_nxt = 1'b1;
        step_nxt = 4'd0;
        cur_nxt  = q_data.bits;
        last_nxt = q_data.last;
        pad_nxt  = q_data.pad;
      end
    end else if (adv) begin
      out_tvalid_nxt = 1'b1;
      if (step_r == DIGIT_STP) begin
        out_tdata_nxt = {1'b0, ZERO_CHAR + {4'd0, pad_r}};
        out_tlast_nxt = 1'b1;
        busy_nxt      = 1'b0;
      end else begin
        out_tlast_nxt = 1'b0;
        if (step_r[0]) begin
          out_tdata_nxt = {1'b0, sym_char(odd_sym(slice))};
          cur_nxt       = cur_r << SLICE_BITS;
        end else begin
          out_tdata_nxt = {1'b0, sym_char(even_sym(slice))};
        end
        step_nxt = step_r + 4'd1;
        if (step_r == LAST_SYM && !last_r) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      step_r       <= 4'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      step_r       <= step_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    last_r      <= last_nxt;
    pad_r       <= pad_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (step_r <= DIGIT_STP))
    else $error("serializer step out of range");

  a_load_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> (step_r == 4'd0))
    else $error("group loaded with a stale step");

  a_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tlast_r) |->
      (out_tdata_r[6:0] >= ZERO_CHAR && out_tdata_r[6:0] <= ZERO_CHAR + 7'd4))
    else $error("final word is not a pad-count digit");
`endif

endmodule
`default_nettype wire

// ===== rtl/interleaved_base32_text_encoder_core.sv =====
// A completed group is registered in the group queue, then in the serializer's group register.
// Its characters follow one per cycle while out_tready is high: eight per group, nine at stream end.
// Input takes one byte per cycle while the group queue has room.
// The serializer sets the sustained rate: it loads each group in a state that sends no character.
// Reset clears the byte count, the queue and the output valid; held group bytes are not cleared.
`default_nettype none
module interleaved_base32_text_encoder_core #(
  parameter int QDEPTH = ib32_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [6:0] text_char, [7] zero
  output logic            out_tlast   // final_char
);
  import ib32_pkg::*;

  logic   push, full, pop, q_valid;
  group_t push_data, q_data;

  ib32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (full)
  );

  ib32_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ib32_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/ib32_char_checker.sv =====
// Checker that predicts the encoder's output characters from accepted input words and compares them.
`timescale 1ns / 1ps
module ib32_char_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // end_of_stream
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,  // [6:0] text_char, [7] zero
  input  wire logic       out_tlast,  // final_char
  output int              errors,
  output int              pending
);
  import ib32_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       fin;
  } text_char_t;

  text_char_t awaited_chars[$];
  logic [7:0] held_bytes [HOLD_DEPTH];
  logic [2:0] held_count;
  int         fail_cnt;

  initial begin
    errors = 0;
    pending = 0;
    fail_cnt = 0;
    held_count = 3'd0;
  end

  function automatic logic [6:0] char_of_symbol(input logic [4:0] sym);
    logic [6:0] wide;
    wide = {2'b00, sym};
    if (sym < LETTER_COUNT) begin
      return wide + LETTER_BASE;
    end
    return wide + DIGIT_BASE;
  endfunction

  function automatic void encode_byte(input logic [7:0] b, input logic eos);
    logic [GROUP_BITS-1:0] grp;
    logic [7:0]            cur;
    logic [SLICE_BITS-1:0] slice;
    logic [4:0]            ev;
    logic [4:0]            od;
    logic [6:0]            pad_cnt;
    int                    count;
    text_char_t            c;
    if (!eos && held_count < HOLD_DEPTH) begin
      held_bytes[held_count[1:0]] = b;
      held_count = held_count + 3'd1;
      return;
    end
    count = held_count + 1;
    grp = '0;
    for (int i = 0; i < GROUP_LEN; i++) begin
      if (i < held_count) begin
        cur = held_bytes[i];
      end else if (i == held_count) begin
        cur = b;
      end else if (i == count) begin
        cur = PAD_MARK;
      end else begin
        cur = 8'h00;
      end
      grp = {grp[GROUP_BITS-9:0], cur};
    end
    for (int s = 0; s < SYMS_PER_GRP / 2; s++) begin
      slice = grp[GROUP_BITS-1-SLICE_BITS*s -: SLICE_BITS];
      for (int k = 0; k < 5; k++) begin
        ev[4-k] = slice[9-2*k];
        od[4-k] = slice[8-2*k];
      end
      c.ch = char_of_symbol(ev);
      c.fin = 1'b0;
      awaited_chars.push_back(c);
      c.ch = char_of_symbol(od);
      awaited_chars.push_back(c);
    end
    if (eos) begin
      pad_cnt = 7'(GROUP_LEN - count);
      c.ch = ZERO_CHAR + pad_cnt;
      c.fin = 1'b1;
      awaited_chars.push_back(c);
    end
    held_count = 3'd0;
  endfunction

  always @(posedge clk) begin
    text_char_t e;
    if (!rst_n) begin
      awaited_chars.delete();
      held_count = 3'd0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_chars.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected word: expected none, actual tdata=%h tlast=%b",
                   $time, out_tdata, out_tlast);
        end else begin
          e = awaited_chars.pop_front();
          if (out_tdata !== {1'b0, e.ch} || out_tlast !== e.fin) begin
            fail_cnt++;
            $display("%0t: mismatch: expected tdata=%h tlast=%b, actual tdata=%h tlast=%b",
                     $time, {1'b0, e.ch}, e.fin, out_tdata, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        encode_byte(in_tdata, in_tlast);
      end
    end
    errors <= fail_cnt;
    pending <= awaited_chars.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top-level testbench: clock, reset, byte stream stimulus and the final verdict for the encoder.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 95;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tready = 1'b0;
  wire logic       in_tready;
  wire logic       out_tvalid;
  wire logic [7:0] out_tdata;
  wire logic       out_tlast;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int sent = 0;

  always #6 clk = ~clk;

  interleaved_base32_text_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ib32_char_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    sent++;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random_stream();
    int len;
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(40, 11);
    end else begin
      len = $urandom_range(10, 1);
    end
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short streams of one to six bytes cover every pad count and a group boundary.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b1);
    for (int i = 0; i < 5; i++) begin
      send_byte(8'hFF, i == 4);
    end
    for (int i = 0; i < 5; i++) begin
      send_byte(8'h00, 1'b0);
    end
    send_byte(8'hC3, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 56;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 56;
        end
        default: begin
          idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      while (sent < 21 + PHASE_WORDS * (ph + 1)) begin
        send_random_stream();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ib32_pkg.sv
rtl/ib32_front.sv
rtl/ib32_queue.sv
rtl/ib32_back.sv
rtl/interleaved_base32_text_encoder_core.sv
tb/ib32_char_checker.sv
tb/tb_top.sv
